@@ src/pdt_pkg.sv @@
// Shared types, widths and codes of the watched-descriptor table.
`timescale 1ns / 1ps

package pdt_pkg;

    localparam int SLOTS            = 64;
    localparam int DESCRIPTOR_RANGE = 1024;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int MAP_AW  = $clog2(DESCRIPTOR_RANGE);

    localparam int KIND_W     = 3;
    localparam int DESC_W     = 10;
    localparam int CONN_W     = 16;
    localparam int MASK_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOTIDX_W  = 6;
    localparam int ENTRIES_W  = 7;

    localparam int IN_BITS    = KIND_W + DESC_W + CONN_W + MASK_W;
    localparam int OUT_BITS   = STATUS_W + SLOTIDX_W + MASK_W + ENTRIES_W + 1 + DESC_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RX  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET = 3'd4;

    localparam logic [MASK_W-1:0] EV_IN  = 16'h0001;
    localparam logic [MASK_W-1:0] EV_OUT = 16'h0004;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_DUP    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RES_BAD,
        RES_FULL,
        RES_DUP,
        RES_ADD,
        RES_DEL_LAST,
        RES_MOVE,
        RES_EDIT
    } res_src_t;

    typedef struct packed {
        logic [CONN_W-1:0] owner;
        logic [MASK_W-1:0] mask;
        logic [DESC_W-1:0] desc;
    } slot_entry_t;

    typedef struct packed {
        logic     req_load;
        logic     clear_wr;
        logic     add_wr;
        logic     del_clr;
        logic     rd_last;
        logic     rd_idx;
        logic     move_wr;
        logic     edit_wr;
        logic     res_load;
        res_src_t res_src;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic is_add;
        logic is_del;
        logic full;
        logic present;
        logic last_hit;
        logic out_free;
    } sts_t;

endpackage

@@ src/poll_descriptor_table.sv @@
// Top level of the watched-descriptor table: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on the s_ stream, one transaction per request; each request
// produces exactly one result transaction on the m_ stream.
// The result is loaded into the output register from the emit state, which follows
// the lookup state for add, failed requests and delete of the last slot, and
// the move or edit state for a mask edit or a delete that moves a slot; the
// extra state covers the registered read of the slot memory ahead of its write-back.
// The reverse map is read once per request, on the cycle the request is
// accepted.
// A new request is accepted once the previous one has moved into the output
// register, so a waiting result does not block intake of the next request.
// If the receiver stalls, the block completes the next request and then holds
// it until the output register frees up, with s_tready low.
// After reset the reverse map is cleared one entry per cycle, all 1024 entries,
// with s_tready low; the slot count restarts at 1 (slot 0 is reserved).
module poll_descriptor_table import pdt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // kind[2:0], descriptor[12:3], conn_handle[28:13], event_value[44:29]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], slot_index[7:2], mask_after[23:8], entries_used[30:24],
    // moved[31], moved_descriptor[41:32]
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    pdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ src/pdt_datapath.sv @@
// Datapath: request latch, reverse map, slot memory, count, result and output registers.
`timescale 1ns / 1ps

module pdt_datapath import pdt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [KIND_W-1:0] kind_reg;
    logic [DESC_W-1:0] desc_reg;
    logic [CONN_W-1:0] conn_reg;
    logic [MASK_W-1:0] value_reg;

    logic [SLOT_W-1:0] map_mem [DESCRIPTOR_RANGE];
    logic [SLOT_W-1:0] map_q_reg;
    logic              map_we;
    logic [MAP_AW-1:0] map_wa;
    logic [SLOT_W-1:0] map_wd;
    logic [MAP_AW-1:0] map_ra;

    slot_entry_t       slot_mem [SLOTS];
    slot_entry_t       slot_q_reg;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_wa;
    slot_entry_t       slot_wd;
    logic              slot_re;
    logic [SLOT_W-1:0] slot_ra;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [MAP_AW-1:0]  clr_reg, clr_next;

    logic [MASK_W-1:0] edit_mask;
    logic              moved_in_range;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [SLOTIDX_W-1:0] res_slot_reg, res_slot_next;
    logic [MASK_W-1:0]    res_mask_reg, res_mask_next;
    logic [ENTRIES_W-1:0] res_entries_reg;
    logic                 res_moved_reg, res_moved_next;
    logic [DESC_W-1:0]    res_mdesc_reg, res_mdesc_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Request latch, loaded when the input transaction completes.
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            kind_reg  <= s_tdata[KIND_W-1:0];
            desc_reg  <= s_tdata[KIND_W +: DESC_W];
            conn_reg  <= s_tdata[KIND_W + DESC_W +: CONN_W];
            value_reg <= s_tdata[KIND_W + DESC_W + CONN_W +: MASK_W];
        end
    end

    assign map_ra         = MAP_AW'(s_tdata[KIND_W +: DESC_W]);
    assign moved_in_range = int'(slot_q_reg.desc) < DESCRIPTOR_RANGE;

    always_comb begin
        map_we = 1'b0;
        map_wa = MAP_AW'(desc_reg);
        map_wd = '0;
        if (cmd.clear_wr) begin
            map_we = 1'b1;
            map_wa = clr_reg;
        end else if (cmd.add_wr) begin
            map_we = 1'b1;
            map_wd = SLOT_W'(count_reg);
        end else if (cmd.del_clr) begin
            map_we = 1'b1;
        end else if (cmd.move_wr) begin
            // The moved descriptor now points at the hole.
            map_we = moved_in_range;
            map_wa = MAP_AW'(slot_q_reg.desc);
            map_wd = map_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (cmd.req_load) begin
            map_q_reg <= map_mem[map_ra];
        end
    end

    always_comb begin
        case (kind_reg)
            KIND_RX: edit_mask = (slot_q_reg.mask & ~EV_IN) | value_reg;
            KIND_TX: edit_mask = (slot_q_reg.mask & ~EV_OUT) | value_reg;
            default: edit_mask = value_reg;
        endcase
    end

    always_comb begin
        slot_we = cmd.add_wr | cmd.move_wr | cmd.edit_wr;
        slot_wa = map_q_reg;
        slot_wd = slot_q_reg;
        if (cmd.add_wr) begin
            slot_wa = SLOT_W'(count_reg);
            slot_wd = '{owner: conn_reg, mask: value_reg, desc: desc_reg};
        end else if (cmd.edit_wr) begin
            slot_wd.mask = edit_mask;
        end
        slot_re = cmd.rd_last | cmd.rd_idx;
        slot_ra = cmd.rd_last ? SLOT_W'(count_reg - COUNT_W'(1)) : map_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            slot_q_reg <= slot_mem[slot_ra];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.add_wr) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (cmd.del_clr) begin
            count_next = count_reg - COUNT_W'(1);
        end
        clr_next = cmd.clear_wr ? clr_reg + MAP_AW'(1) : clr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_W'(1);
            clr_reg   <= '0;
        end else begin
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        sts.clear_last = clr_reg == MAP_AW'(DESCRIPTOR_RANGE - 1);
        sts.bad        = (kind_reg > KIND_SET) || (int'(desc_reg) >= DESCRIPTOR_RANGE);
        sts.is_add     = kind_reg == KIND_ADD;
        sts.is_del     = kind_reg == KIND_DEL;
        sts.full       = count_reg >= COUNT_W'(SLOTS);
        sts.present    = (map_q_reg != '0) && (COUNT_W'(map_q_reg) < count_reg);
        sts.last_hit   = COUNT_W'(map_q_reg) == count_reg - COUNT_W'(1);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        res_status_next = STAT_DONE;
        res_slot_next   = SLOTIDX_W'(map_q_reg);
        res_mask_next   = '0;
        res_moved_next  = 1'b0;
        res_mdesc_next  = '0;
        case (cmd.res_src)
            RES_BAD: begin
                res_status_next = STAT_ABSENT;
                res_slot_next   = '0;
            end
            RES_FULL: begin
                res_status_next = STAT_FULL;
                res_slot_next   = '0;
            end
            RES_DUP: begin
                res_status_next = STAT_DUP;
                res_slot_next   = '0;
            end
            RES_ADD: begin
                res_slot_next = SLOTIDX_W'(count_reg);
                res_mask_next = value_reg;
            end
            RES_DEL_LAST: begin
                res_mask_next = '0;
            end
            RES_MOVE: begin
                res_mask_next  = slot_q_reg.mask;
                res_moved_next = 1'b1;
                res_mdesc_next = slot_q_reg.desc;
            end
            RES_EDIT: begin
                res_mask_next = edit_mask;
            end
            default: begin
                res_status_next = STAT_ABSENT;
                res_slot_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg  <= res_status_next;
            res_slot_reg    <= res_slot_next;
            res_mask_reg    <= res_mask_next;
            res_entries_reg <= ENTRIES_W'(count_next);
            res_moved_reg   <= res_moved_next;
            res_mdesc_reg   <= res_mdesc_next;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({res_mdesc_reg, res_moved_reg, res_entries_reg,
                                       res_mask_reg, res_slot_reg, res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ src/pdt_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps

module pdt_ctrl import pdt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_LOOKUP = 6'b000100,
        ST_MOVE   = 6'b001000,
        ST_EDIT   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_src  = RES_BAD;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.res_load = 1'b1;
                state_next   = ST_EMIT;
                if (sts.bad) begin
                    cmd.res_src = RES_BAD;
                end else if (sts.is_add) begin
                    if (sts.full) begin
                        cmd.res_src = RES_FULL;
                    end else if (sts.present) begin
                        cmd.res_src = RES_DUP;
                    end else begin
                        cmd.add_wr  = 1'b1;
                        cmd.res_src = RES_ADD;
                    end
                end else if (!sts.present) begin
                    cmd.res_src = RES_BAD;
                end else if (sts.is_del) begin
                    cmd.del_clr = 1'b1;
                    if (sts.last_hit) begin
                        cmd.res_src = RES_DEL_LAST;
                    end else begin
                        // Fetch the last slot so it can fill the hole.
                        cmd.res_load = 1'b0;
                        cmd.rd_last  = 1'b1;
                        state_next   = ST_MOVE;
                    end
                end else begin
                    cmd.res_load = 1'b0;
                    cmd.rd_idx   = 1'b1;
                    state_next   = ST_EDIT;
                end
            end
            ST_MOVE: begin
                cmd.move_wr  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_src  = RES_MOVE;
                state_next   = ST_EMIT;
            end
            ST_EDIT: begin
                cmd.edit_wr  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_src  = RES_EDIT;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/pdt_checker.sv @@
// Port-level checker for the watched-descriptor table and its bind statement.
`timescale 1ns / 1ps

module pdt_checker import pdt_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ENT_LO = STATUS_W + SLOTIDX_W + MASK_W;

    logic [STATUS_W-1:0]  out_status;
    logic [ENTRIES_W-1:0] out_entries;

    assign out_status  = m_tdata[STATUS_W-1:0];
    assign out_entries = m_tdata[ENT_LO +: ENTRIES_W];

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: intake closes right after a transaction.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted back to back");

    // A result never appears on the cycle right after its request.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // Reset leaves both channels quiet while the map is being cleared.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("channel active right after reset");

    // The reserved slot is always counted, and a full report sees a full table.
    a_count_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_entries != '0 &&
            (out_status != STAT_FULL || out_entries == ENTRIES_W'(SLOTS)))
        else $error("slot count in result is inconsistent");

endmodule

bind poll_descriptor_table pdt_checker u_pdt_checker (.*);
